@@ hw/rtl/bfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Block free-list allocator package
// Shared widths, codes and structures for the linked free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfla_pkg;

    localparam int unsigned NUM_BLOCKS = 1024;
    localparam int unsigned MAX_RUN    = 16;
    localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
    localparam int unsigned LINK_W     = IDX_W + 1;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned RUN_W      = 5;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned SHIFT_W    = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [LINK_W-1:0]  POOL_RESET  = LINK_W'(1024);
    localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

    typedef enum logic [OP_W-1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BLOCKS = 2'd0,
        CFG_REGION_BASE = 2'd1,
        CFG_BLOCK_SHIFT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FORMAT,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RUN_W-1:0] alloc_count;
        logic [IDX_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [LINK_W-1:0] first;
        logic [LINK_W-1:0] free_count;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

@@ hw/rtl/bfla_if.sv @@
// ----------------------------------------------------------------------------
// Block free-list allocator channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfla_req_if;
    logic                          valid;
    logic                          ready;
    logic [bfla_pkg::OP_W-1:0]     op;
    logic [bfla_pkg::RUN_W-1:0]    alloc_count;
    logic [bfla_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, output op, output alloc_count, output block_index,
                    input ready);
    modport sink   (input valid, input op, input alloc_count, input block_index,
                    output ready);
endinterface

interface bfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [bfla_pkg::ADDR_W-1:0]   block_address;
    logic [bfla_pkg::IDX_W-1:0]    block_number;
    logic [bfla_pkg::LINK_W-1:0]   free_count;

    modport source (output valid, output status, output block_address,
                    output block_number, output free_count, input ready);
    modport sink   (input valid, input status, input block_address,
                    input block_number, input free_count, output ready);
endinterface

interface bfla_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bfla_pkg::CFG_IDX_W-1:0]    index;
    logic [bfla_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Block free-list allocator
// A free or a refused allocate goes straight to its result; an allocate of n
// blocks first walks n links, and a format first writes one link per pool block.
// One item at a time; an allocate is bound by one link-store read per block.
// A new request is taken while the previous result waits in the output register.
// Reset empties the free list (head 0, count 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfla_req_if.sink    i_req,
    bfla_rsp_if.source  o_rsp,
    bfla_cfg_if.sink    i_cfg
);

    logic [bfla_pkg::LINK_W-1:0]  r_pool_blocks;
    logic [bfla_pkg::ADDR_W-1:0]  r_region_base;
    logic [bfla_pkg::SHIFT_W-1:0] r_block_shift;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic [bfla_pkg::ADDR_W-1:0]  r_out_address;
    logic [bfla_pkg::IDX_W-1:0]   r_out_number;
    logic [bfla_pkg::LINK_W-1:0]  r_out_free;

    bfla_pkg::t_req               w_req;
    bfla_pkg::t_res               w_res;
    bfla_pkg::t_ram_req           w_ram_req;
    logic [bfla_pkg::LINK_W-1:0]  w_ram_rdata;
    logic                         w_res_valid;
    logic                         w_res_ready;
    logic                         w_req_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_blocks <= bfla_pkg::POOL_RESET;
            r_region_base <= bfla_pkg::BASE_RESET;
            r_block_shift <= bfla_pkg::SHIFT_RESET;
        end else if (i_cfg.valid) begin
            case (bfla_pkg::t_cfg_idx'(i_cfg.index))
                bfla_pkg::CFG_POOL_BLOCKS: r_pool_blocks <= i_cfg.data[bfla_pkg::LINK_W-1:0];
                bfla_pkg::CFG_REGION_BASE: r_region_base <= i_cfg.data[bfla_pkg::ADDR_W-1:0];
                bfla_pkg::CFG_BLOCK_SHIFT: r_block_shift <= i_cfg.data[bfla_pkg::SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_req.op          = i_req.op;
    assign w_req.alloc_count = i_req.alloc_count;
    assign w_req.block_index = i_req.block_index;
    assign i_req.ready       = w_req_ready;

    bfla_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (w_req_ready),
        .i_req         (w_req),
        .i_pool_blocks (r_pool_blocks),
        .o_ram_req     (w_ram_req),
        .i_ram_rdata   (w_ram_rdata),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res)
    );

    bfla_link_ram u_link_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    // The output register frees the engine as soon as its result is taken over.
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_status <= w_res.status;
            r_out_free   <= w_res.free_count;
            if (w_res.hit) begin
                r_out_number  <= w_res.first[bfla_pkg::IDX_W-1:0];
                r_out_address <= r_region_base +
                                 (bfla_pkg::ADDR_W'(w_res.first) << r_block_shift);
            end else begin
                r_out_number  <= '0;
                r_out_address <= '0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.block_address = r_out_address;
    assign o_rsp.block_number  = r_out_number;
    assign o_rsp.free_count    = r_out_free;

endmodule

@@ hw/rtl/bfla_link_ram.sv @@
// ----------------------------------------------------------------------------
// Next-link store
// One write port and one read port; read data is registered in the cycle after the read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfla_link_ram (
    input  logic                          i_clk,
    input  bfla_pkg::t_ram_req            i_req,
    output logic [bfla_pkg::LINK_W-1:0]   o_rdata
);

    logic [bfla_pkg::LINK_W-1:0] r_mem [bfla_pkg::NUM_BLOCKS];
    logic [bfla_pkg::LINK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bfla_engine.sv @@
// ----------------------------------------------------------------------------
// Free-list sequencer
// Formats the pool, walks the links for an allocate and pushes frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfla_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  bfla_pkg::t_req                i_req,
    input  logic [bfla_pkg::LINK_W-1:0]   i_pool_blocks,
    output bfla_pkg::t_ram_req            o_ram_req,
    input  logic [bfla_pkg::LINK_W-1:0]   i_ram_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bfla_pkg::t_res                o_res
);

    localparam logic [bfla_pkg::LINK_W-1:0] NumBlocks = bfla_pkg::LINK_W'(bfla_pkg::NUM_BLOCKS);
    localparam logic [bfla_pkg::RUN_W-1:0]  MaxRun    = bfla_pkg::RUN_W'(bfla_pkg::MAX_RUN);

    bfla_pkg::t_state            r_state, n_state;
    logic [bfla_pkg::LINK_W-1:0] r_head, n_head;
    logic [bfla_pkg::LINK_W-1:0] r_total, n_total;
    logic [bfla_pkg::LINK_W-1:0] r_limit, n_limit;
    logic [bfla_pkg::LINK_W-1:0] r_idx, n_idx;
    logic [bfla_pkg::RUN_W-1:0]  r_rem, n_rem;
    logic                        r_oob, n_oob;
    logic [bfla_pkg::LINK_W-1:0] r_first, n_first;
    logic                        r_status, n_status;
    logic                        r_hit, n_hit;
    logic [bfla_pkg::LINK_W-1:0] w_cur;
    logic [bfla_pkg::LINK_W-1:0] w_run;

    // A link that points past the store reads as block zero.
    assign w_cur = r_oob ? '0 : i_ram_rdata;
    assign w_run = bfla_pkg::LINK_W'(i_req.alloc_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfla_pkg::ST_IDLE;
            r_head  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit  <= n_limit;
        r_idx    <= n_idx;
        r_rem    <= n_rem;
        r_oob    <= n_oob;
        r_first  <= n_first;
        r_status <= n_status;
        r_hit    <= n_hit;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_total     = r_total;
        n_limit     = r_limit;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_oob       = r_oob;
        n_first     = r_first;
        n_status    = r_status;
        n_hit       = r_hit;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_ram_req   = '0;

        unique case (r_state)
            bfla_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_status = 1'b0;
                    n_hit    = 1'b0;
                    n_first  = '0;
                    n_state  = bfla_pkg::ST_DONE;
                    case (bfla_pkg::t_op'(i_req.op))
                        bfla_pkg::OP_FORMAT: begin
                            n_limit = (i_pool_blocks > NumBlocks) ? NumBlocks : i_pool_blocks;
                            n_idx   = '0;
                            n_state = bfla_pkg::ST_FORMAT;
                        end
                        bfla_pkg::OP_ALLOC: begin
                            if (i_req.alloc_count == '0 || i_req.alloc_count > MaxRun ||
                                r_total < w_run) begin
                                n_status = 1'b1;
                            end else begin
                                n_hit           = 1'b1;
                                n_first         = r_head;
                                n_total         = r_total - w_run;
                                n_rem           = i_req.alloc_count;
                                o_ram_req.re    = 1'b1;
                                o_ram_req.raddr = r_head[bfla_pkg::IDX_W-1:0];
                                n_oob           = r_head[bfla_pkg::IDX_W];
                                n_state         = bfla_pkg::ST_WALK;
                            end
                        end
                        bfla_pkg::OP_FREE: begin
                            // The index field cannot exceed the store, so only a full
                            // list turns a free away.
                            if (r_total < NumBlocks) begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = i_req.block_index;
                                o_ram_req.wdata = r_head;
                                n_head          = bfla_pkg::LINK_W'(i_req.block_index);
                                n_total         = r_total + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bfla_pkg::ST_FORMAT: begin
                if (r_idx == r_limit) begin
                    n_head  = '0;
                    n_total = r_limit;
                    n_state = bfla_pkg::ST_DONE;
                end else begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_idx[bfla_pkg::IDX_W-1:0];
                    o_ram_req.wdata = r_idx + 1'b1;
                    n_idx           = r_idx + 1'b1;
                end
            end
            bfla_pkg::ST_WALK: begin
                // Each cycle consumes one link and issues the read for the next.
                n_rem = r_rem - 1'b1;
                if (r_rem == bfla_pkg::RUN_W'(1)) begin
                    n_head  = w_cur;
                    n_state = bfla_pkg::ST_DONE;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = w_cur[bfla_pkg::IDX_W-1:0];
                    n_oob           = w_cur[bfla_pkg::IDX_W];
                end
            end
            bfla_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = bfla_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfla_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.status     = r_status;
    assign o_res.hit        = r_hit;
    assign o_res.first      = r_first;
    assign o_res.free_count = r_total;

endmodule

@@ hw/rtl/bfla_checker.sv @@
// ----------------------------------------------------------------------------
// Block free-list allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfla_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_status,
    input logic [bfla_pkg::ADDR_W-1:0]   i_rsp_address,
    input logic [bfla_pkg::IDX_W-1:0]    i_rsp_number,
    input logic [bfla_pkg::LINK_W-1:0]   i_rsp_free
);

    logic [1:0] r_pending;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_req_valid && i_req_ready;
    assign w_out_xfer = i_rsp_valid && i_rsp_ready;

    // Requests taken whose results have not yet been transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, w_in_xfer} - {1'b0, w_out_xfer};
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 2'd0)
        else $error("result presented with no request outstanding");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_address) &&
        $stable(i_rsp_free) && $stable(i_rsp_status))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_free <= bfla_pkg::LINK_W'(bfla_pkg::NUM_BLOCKS))
        else $error("free count above pool capacity");

    a_refusal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status |-> i_rsp_number == '0 && i_rsp_address == '0)
        else $error("refused allocate reports a block");

endmodule

bind block_free_list_allocator bfla_checker u_bfla_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_address (o_rsp.block_address),
    .i_rsp_number  (o_rsp.block_number),
    .i_rsp_free    (o_rsp.free_count)
);
